### hw/rtl/ksis_pkg.sv
package ksis_pkg;

    localparam int MAX_INTERVALS = 1024;
    localparam int ADDR_W        = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = 11;
    localparam int MAX_SERVERS   = 16;
    localparam int SRV_W         = $clog2(MAX_SERVERS);
    localparam int SCNT_W        = 5;
    localparam int TIME_W        = 32;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic rd_jm1;
        logic ld_key;
        logic shift;
        logic wr_key;
        logic sch_init;
        logic scan;
        logic upd;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic i_lt_n;
        logic j_zero;
        logic cmp_gt;
        logic scan_done;
    } t_dp_stat;

endpackage

### hw/rtl/ksis_datapath.sv
module ksis_datapath
    import ksis_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SCNT_W-1:0]   i_cfg_wdata,
    input  logic [TIME_W-1:0]   i_interval_start,
    input  logic [TIME_W-1:0]   i_interval_end,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_result_valid,
    output logic [CNT_W-1:0]    o_scheduled_count,
    output logic                o_overflow
);

    logic [2*TIME_W-1:0] r_mem [MAX_INTERVALS];
    logic [2*TIME_W-1:0] r_rd_data;
    logic [SCNT_W-1:0]   r_server_count;
    logic [CNT_W-1:0]    r_load_count;
    logic                r_drop;
    logic [CNT_W-1:0]    r_i;
    logic [CNT_W-1:0]    r_j;
    logic [TIME_W-1:0]   r_key_start;
    logic [TIME_W-1:0]   r_key_end;
    logic [TIME_W-1:0]   r_free [MAX_SERVERS];
    logic [SCNT_W-1:0]   r_m;
    logic                r_found;
    logic [SRV_W-1:0]    r_best;
    logic [CNT_W-1:0]    r_count;
    logic                r_valid;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_out_drop;

    logic                full;
    logic [SCNT_W-1:0]   servers;
    logic [CNT_W-1:0]    jm1;
    logic [TIME_W-1:0]   f;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [2*TIME_W-1:0] wdata;
    logic [ADDR_W-1:0]   raddr;

    assign full    = (r_load_count == CNT_W'(MAX_INTERVALS));
    assign servers = (r_server_count > SCNT_W'(MAX_SERVERS)) ? SCNT_W'(MAX_SERVERS)
                                                             : r_server_count;
    assign jm1     = r_j - CNT_W'(1);
    assign f       = r_free[r_m[SRV_W-1:0]];

    always_comb begin
        we    = 1'b0;
        waddr = r_j[ADDR_W-1:0];
        wdata = {r_key_start, r_key_end};
        if (i_cmd.load && !full) begin
            we    = 1'b1;
            waddr = r_load_count[ADDR_W-1:0];
            wdata = {i_interval_start, i_interval_end};
        end else if (i_cmd.shift) begin
            we    = 1'b1;
            wdata = r_rd_data;
        end else if (i_cmd.wr_key) begin
            we    = 1'b1;
        end
        raddr = i_cmd.rd_jm1 ? jm1[ADDR_W-1:0] : r_i[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_data <= r_mem[raddr];
    end

    assign o_stat.i_lt_n    = (r_i < r_load_count);
    assign o_stat.j_zero    = (r_j == '0);
    assign o_stat.cmp_gt    = (r_rd_data[TIME_W-1:0] > r_key_end);
    assign o_stat.scan_done = (r_m >= servers);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count <= SCNT_W'(1);
            r_load_count   <= '0;
            r_drop         <= 1'b0;
            r_i            <= '0;
            r_j            <= '0;
            r_m            <= '0;
            r_found        <= 1'b0;
            r_count        <= '0;
            r_valid        <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cfg_we) begin
                r_server_count <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                if (full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_load_count <= r_load_count + CNT_W'(1);
                end
            end
            if (i_cmd.sort_init) begin
                r_i <= CNT_W'(1);
                r_j <= '0;
            end
            if (i_cmd.ld_key) begin
                r_j     <= r_i;
                r_m     <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.shift) begin
                r_j <= jm1;
            end
            if (i_cmd.wr_key) begin
                r_i <= r_i + CNT_W'(1);
            end
            if (i_cmd.sch_init) begin
                r_i     <= '0;
                r_j     <= '0;
                r_count <= '0;
            end
            if (i_cmd.scan) begin
                r_m <= r_m + SCNT_W'(1);
                if (f <= r_key_start && (!r_found || f > r_free[r_best])) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.upd) begin
                r_i <= r_i + CNT_W'(1);
                if (r_found) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.finish) begin
                r_load_count <= '0;
                r_drop       <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_key) begin
            r_key_start <= r_rd_data[2*TIME_W-1:TIME_W];
            r_key_end   <= r_rd_data[TIME_W-1:0];
        end
        if (i_cmd.scan && f <= r_key_start && (!r_found || f > r_free[r_best])) begin
            r_best <= r_m[SRV_W-1:0];
        end
        if (i_cmd.sch_init) begin
            for (int k = 0; k < MAX_SERVERS; k++) begin
                r_free[k] <= '0;
            end
        end else if (i_cmd.upd && r_found) begin
            r_free[r_best] <= r_key_end;
        end
        if (i_cmd.finish) begin
            r_out_count <= r_count;
            r_out_drop  <= r_drop;
        end
    end

    assign o_result_valid    = r_valid;
    assign o_scheduled_count = r_out_count;
    assign o_overflow        = r_out_drop;

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count <= CNT_W'(MAX_INTERVALS)) else $error("load count past store depth");
    a_j_le_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j <= r_i) else $error("insert position beyond current item");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m <= SCNT_W'(MAX_SERVERS)) else $error("server scan ran past last server");
    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_load_count == '0 && !r_drop)) else $error("set not cleared after result");

endmodule

### hw/rtl/ksis_ctrl.sv
module ksis_ctrl
    import ksis_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_is_last,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SORT_INI = 4'd1;
    localparam logic [3:0] ST_SORT_RDI = 4'd2;
    localparam logic [3:0] ST_SORT_LD  = 4'd3;
    localparam logic [3:0] ST_SORT_RDJ = 4'd4;
    localparam logic [3:0] ST_SORT_CMP = 4'd5;
    localparam logic [3:0] ST_SORT_WR  = 4'd6;
    localparam logic [3:0] ST_SCH_INI  = 4'd7;
    localparam logic [3:0] ST_SCH_RD   = 4'd8;
    localparam logic [3:0] ST_SCH_LD   = 4'd9;
    localparam logic [3:0] ST_SCH_SCAN = 4'd10;
    localparam logic [3:0] ST_SCH_UPD  = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = start;
                if (start && i_is_last) begin
                    n_state = ST_SORT_INI;
                end
            end
            ST_SORT_INI: begin
                o_cmd.sort_init = 1'b1;
                n_state         = ST_SORT_RDI;
            end
            ST_SORT_RDI: begin
                // store read address defaults to r_i
                if (i_stat.i_lt_n) begin
                    n_state = ST_SORT_LD;
                end else begin
                    n_state = ST_SCH_INI;
                end
            end
            ST_SORT_LD: begin
                o_cmd.ld_key = 1'b1;
                n_state      = ST_SORT_RDJ;
            end
            ST_SORT_RDJ: begin
                if (i_stat.j_zero) begin
                    n_state = ST_SORT_WR;
                end else begin
                    o_cmd.rd_jm1 = 1'b1;
                    n_state      = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP: begin
                if (i_stat.cmp_gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = ST_SORT_RDJ;
                end else begin
                    n_state = ST_SORT_WR;
                end
            end
            ST_SORT_WR: begin
                o_cmd.wr_key = 1'b1;
                n_state      = ST_SORT_RDI;
            end
            ST_SCH_INI: begin
                o_cmd.sch_init = 1'b1;
                n_state        = ST_SCH_RD;
            end
            ST_SCH_RD: begin
                if (i_stat.i_lt_n) begin
                    n_state = ST_SCH_LD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCH_LD: begin
                o_cmd.ld_key = 1'b1;
                n_state      = ST_SCH_SCAN;
            end
            ST_SCH_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_SCH_UPD;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_SCH_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_SCH_RD;
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cmd.load) else $error("item taken while busy");
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_is_last) |=> r_state == ST_SORT_INI)
        else $error("last item did not start run");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !busy) else $error("run did not return to idle");

endmodule

### hw/rtl/k_server_interval_scheduler.sv
// one item per cycle while idle; the is_last item starts the run and raises busy
// run: insertion sort by end time over the stored intervals
// then per interval a server scan over min(server_count,16) servers
// result strobe in the cycle after the done state, busy drops with it; no stall on output
// synchronous active-low reset: servers=1, set empty, no store clearing pass
module k_server_interval_scheduler
    import ksis_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [TIME_W-1:0] i_interval_start,
    input  logic [TIME_W-1:0] i_interval_end,
    input  logic              i_is_last,
    input  logic              i_cfg_we,
    input  logic [SCNT_W-1:0] i_cfg_wdata,
    output logic              o_result_valid,
    output logic [CNT_W-1:0]  o_scheduled_count,
    output logic              o_overflow
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ksis_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_is_last (i_is_last),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .busy      (busy)
    );

    ksis_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_interval_start  (i_interval_start),
        .i_interval_end    (i_interval_end),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_result_valid    (o_result_valid),
        .o_scheduled_count (o_scheduled_count),
        .o_overflow        (o_overflow)
    );

endmodule

### test/k_server_interval_scheduler_test.sv
module k_server_interval_scheduler_test
    import ksis_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_end;
        logic              last;
    } t_interval;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic             overflow;
    } t_outcome;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [TIME_W-1:0] i_interval_start = '0;
    logic [TIME_W-1:0] i_interval_end = '0;
    logic              i_is_last = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [SCNT_W-1:0] i_cfg_wdata = '0;
    logic              o_result_valid;
    logic [CNT_W-1:0]  o_scheduled_count;
    logic              o_overflow;

    k_server_interval_scheduler dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_interval_start  (i_interval_start),
        .i_interval_end    (i_interval_end),
        .i_is_last         (i_is_last),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_result_valid    (o_result_valid),
        .o_scheduled_count (o_scheduled_count),
        .o_overflow        (o_overflow)
    );

    t_interval pending_items[$];
    t_interval loaded_set[$];
    t_outcome  expected_counts[$];
    logic      set_dropped = 1'b0;
    int        active_servers = 1;
    int        mismatches = 0;
    int        results_seen = 0;
    int        items_sent = 0;
    int        idle_cycles = 0;
    bit        steady_sender = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // greedy count over one set: sort by end, best-fit server with latest free time
    function automatic int count_scheduled(t_interval set_in[$], int servers);
        t_interval         ivs[$];
        t_interval         key;
        logic [TIME_W-1:0] free_at[MAX_SERVERS];
        int                j;
        int                best;
        bit                found;
        int                total;
        ivs = set_in;
        total = 0;
        if (servers > MAX_SERVERS) begin
            servers = MAX_SERVERS;
        end
        for (int m = 0; m < MAX_SERVERS; m++) begin
            free_at[m] = '0;
        end
        for (int i = 1; i < ivs.size(); i++) begin
            key = ivs[i];
            j = i;
            while (j > 0 && ivs[j-1].t_end > key.t_end) begin
                ivs[j] = ivs[j-1];
                j--;
            end
            ivs[j] = key;
        end
        for (int i = 0; i < ivs.size(); i++) begin
            found = 1'b0;
            best = 0;
            for (int m = 0; m < servers; m++) begin
                if (free_at[m] <= ivs[i].t_start && (!found || free_at[m] > free_at[best])) begin
                    best = m;
                    found = 1'b1;
                end
            end
            if (found) begin
                total++;
                free_at[best] = ivs[i].t_end;
            end
        end
        return total;
    endfunction

    // driver
    always @(posedge i_clk) begin : driver
        int        gap;
        bit        drive_next;
        t_interval taken;
        t_outcome  outcome;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap = 0;
        end else begin
            if (start && !busy) begin
                taken = pending_items.pop_front();
                items_sent++;
                if (loaded_set.size() < MAX_INTERVALS) begin
                    loaded_set.push_back(taken);
                end else begin
                    set_dropped = 1'b1;
                end
                if (taken.last) begin
                    outcome.count = CNT_W'(count_scheduled(loaded_set, active_servers));
                    outcome.overflow = set_dropped;
                    expected_counts.push_back(outcome);
                    loaded_set.delete();
                    set_dropped = 1'b0;
                end
                if (!steady_sender) begin
                    case ($urandom_range(9))
                        0, 1, 2:  gap = $urandom_range(1, 3);
                        3:        gap = $urandom_range(5, 40);
                        default:  gap = 0;
                    endcase
                end
            end
            drive_next = 1'b0;
            if (gap > 0) begin
                gap--;
            end else if (pending_items.size() > 0) begin
                drive_next = 1'b1;
            end
            start <= drive_next;
            if (drive_next) begin
                i_interval_start <= pending_items[0].t_start;
                i_interval_end   <= pending_items[0].t_end;
                i_is_last        <= pending_items[0].last;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (i_rst_n && o_result_valid) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: count %0d overflow %0d",
                             o_scheduled_count, o_overflow);
                end
            end else begin
                want = expected_counts.pop_front();
                if (o_scheduled_count !== want.count || o_overflow !== want.overflow) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result mismatch: expected count %0d overflow %0d, got %0d %0d",
                                 want.count, want.overflow, o_scheduled_count, o_overflow);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e, logic last);
        t_interval iv;
        iv.t_start = s;
        iv.t_end = e;
        iv.last = last;
        pending_items.push_back(iv);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_counts.size() > 0 || busy) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_servers(int value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= SCNT_W'(value);
        @(posedge i_clk);
        active_servers = value & ((1 << SCNT_W) - 1);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_random_set(int size);
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
        bit                wide;
        wide = ($urandom_range(5) == 0);
        for (int i = 0; i < size; i++) begin
            if (wide) begin
                s = $urandom();
                e = ($urandom_range(7) == 0) ? $urandom() : s + $urandom_range(0, 1 << 20);
            end else begin
                s = $urandom_range(0, 63);
                e = ($urandom_range(15) == 0) ? $urandom_range(0, 63) : s + $urandom_range(0, 20);
            end
            add_item(s, e, i == size - 1);
        end
    endtask

    initial begin : stimulus
        int sets_done;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset server count of one
        add_item(32'd0, 32'd0, 1'b1);
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_item(32'd10, 32'd20, 1'b0);
        add_item(32'd15, 32'd25, 1'b0);
        add_item(32'd20, 32'd30, 1'b1);
        // end below start
        add_item(32'd50, 32'd5, 1'b0);
        add_item(32'd6, 32'd7, 1'b1);
        set_servers(0);
        add_item(32'd0, 32'd1, 1'b0);
        add_item(32'd3, 32'd4, 1'b1);
        set_servers(2);
        add_item(32'd0, 32'd10, 1'b0);
        add_item(32'd0, 32'd10, 1'b0);
        add_item(32'd0, 32'd10, 1'b0);
        add_item(32'd10, 32'hFFFF_FFFF, 1'b1);
        set_servers(16);
        for (int i = 0; i < 18; i++) begin
            add_item(32'd5, 32'd9, i == 17);
        end
        // above sixteen saturates
        set_servers(31);
        for (int i = 0; i < 18; i++) begin
            add_item(32'd0, 32'hFFFF_FFFF, i == 17);
        end

        // store overflow: ends ascending keeps the sort short, last item dropped too
        set_servers(16);
        for (int i = 0; i < MAX_INTERVALS + 2; i++) begin
            add_item(32'(i), 32'(i + 20), i == MAX_INTERVALS + 1);
        end
        // sender holds until the block has answered everything
        wait_drained();
        add_item(32'd1, 32'd2, 1'b1);

        sets_done = 0;
        while (items_sent + pending_items.size() < 1200) begin
            if (sets_done % 4 == 0) begin
                set_servers($urandom_range(0, 31));
                steady_sender = ($urandom_range(3) == 0);
            end
            add_random_set(($urandom_range(9) == 0) ? $urandom_range(20, 48)
                                                   : $urandom_range(1, 12));
            sets_done++;
            while (pending_items.size() > 40) begin
                @(posedge i_clk);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d intervals in %0d sets, server counts 0 to 31, store overflow",
                 items_sent, results_seen);
        if (mismatches == 0 && expected_counts.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
